// ===== hw/rtl/qpdmpc_pkg.sv =====
// Package for the quadrature decoder with PD position controller.
// Register map, duty codes and torque limits; no dependencies.
package qpdmpc_pkg;

  localparam int unsigned REG_ADDR_W = 4;
  localparam int unsigned REG_DATA_W = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned TORQ_W     = 32;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned CLAMP_SHIFT = 40;

  localparam logic [1:0] REG_PROP_GAIN    = 2'd0;
  localparam logic [1:0] REG_DERIV_GAIN   = 2'd1;
  localparam logic [1:0] REG_DIR_POLARITY = 2'd2;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd30;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd300;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd127;
  localparam logic [DUTY_W-1:0] DUTY_LOW  = 7'd10;

  localparam logic signed [TORQ_W-1:0] TORQ_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [TORQ_W-1:0] TORQ_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic              dir_polarity;
  } cfg_t;

endpackage

// ===== hw/rtl/quadrature_pd_motor_position_control_unit.sv =====
// Top level: quadrature encoder counter with PD torque, PWM duty and direction.
// Six-stage valid/stall pipeline plus APB register port; uses qpdmpc_pkg.
//
//   channel | dir | signals                                          | transaction
//   in      | in  | in_valid_i/in_stall_o, func, enc_a, enc_b, target | valid & !stall
//   out     | out | out_valid_o/out_stall_i, position .. dir_pin      | valid & !stall
//   cfg     | in  | psel, penable, pwrite, paddr, pwdata, prdata      | APB access phase
//
// One item per cycle while out_stall_i is low; each result is registered by every stage in turn.
// The count and fault update in stage two; stages three to six build torque and duty.
// Reset clears the count, the fault flag, the held torque, duty and direction, and
// loads the gains. Each stage holds under a stall only if the stage after it is full.
module quadrature_pd_motor_position_control_unit #(
  parameter int unsigned POS_WIDTH   = 32,
  parameter int unsigned FULL_TORQUE = 4496
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   func_i,
  input  logic                                   enc_a_i,
  input  logic                                   enc_b_i,
  input  logic signed [31:0]                     target_pos_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [31:0]                     position_o,
  output logic                                   enc_fault_o,
  output logic signed [qpdmpc_pkg::TORQ_W-1:0]   torque_o,
  output logic [qpdmpc_pkg::DUTY_W-1:0]          pwm_duty_o,
  output logic                                   dir_pin_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [qpdmpc_pkg::REG_ADDR_W-1:0]      paddr,
  input  logic [qpdmpc_pkg::REG_DATA_W-1:0]      pwdata,
  output logic [qpdmpc_pkg::REG_DATA_W-1:0]      prdata,
  output logic                                   pready
);
  import qpdmpc_pkg::*;

  localparam int unsigned NSTG = 6;
  localparam int unsigned DW   = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 1;
  localparam int unsigned EW   = (DW > 42) ? DW : 42;
  localparam int unsigned CW   = (DW < 42) ? DW : 42;
  localparam int unsigned PW   = CW + GAIN_W + 1;
  localparam int unsigned DPW  = CW + GAIN_W;
  localparam int unsigned TW   = CW + GAIN_W + 2;

  localparam int unsigned DUTY_BIG_MIN = (FULL_TORQUE + 1) / 2;
  localparam int unsigned SMALL_LO     = FULL_TORQUE / 100 + 1;
  localparam int unsigned SMALL_HI     = (FULL_TORQUE - 1) / 25;
  localparam int unsigned MLO_W = (DUTY_BIG_MIN > 1) ? $clog2(DUTY_BIG_MIN) : 1;
  localparam int unsigned XW    = MLO_W + 8;
  localparam int unsigned RSH   = XW + $clog2(FULL_TORQUE);
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << RSH) + 64'(FULL_TORQUE) - 64'd1) / 64'(FULL_TORQUE);
  localparam int unsigned RW    = $clog2(RECIP_64 + 64'd1);
  localparam int unsigned QW    = XW + RW;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_64);

  localparam logic signed [EW-1:0] CLAMP_POS = EW'(1) <<< CLAMP_SHIFT;
  localparam logic signed [EW-1:0] CLAMP_NEG = -CLAMP_POS;

  function automatic logic signed [EW-1:0] clamp_mag(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    r = v;
    if (v > CLAMP_POS) r = CLAMP_POS;
    if (v < CLAMP_NEG) r = CLAMP_NEG;
    return r;
  endfunction

  // configuration
  cfg_t cfg_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_PROP_GAIN:    prdata = REG_DATA_W'(cfg_q.prop_gain);
      REG_DERIV_GAIN:   prdata = REG_DATA_W'(cfg_q.deriv_gain);
      REG_DIR_POLARITY: prdata = REG_DATA_W'(cfg_q.dir_polarity);
      default:          prdata = '0;
    endcase
  end

  // pipeline handshake
  logic [NSTG-1:0] vld_q, vld_d, rdy, load;

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    load[0] = in_valid_i && rdy[0];
    for (int k = 1; k < NSTG; k++) begin
      load[k] = vld_q[k-1] && rdy[k];
    end
    for (int k = 0; k < NSTG - 1; k++) begin
      vld_d[k] = load[k] || (vld_q[k] && !rdy[k+1]);
    end
    vld_d[NSTG-1] = load[NSTG-1] || (vld_q[NSTG-1] && out_stall_i);
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NSTG-1];

  // stage 1: input register
  logic                s1_func_q, s1_a_q, s1_b_q;
  logic signed [31:0]  s1_tgt_q;

  // encoder state
  logic [POS_WIDTH-1:0] count_q, count_d, prev_count_q, cnt_enc;
  logic                 prev_a_q, prev_b_q, fault_q, fault_d, inc, dec;
  logic signed [EW-1:0] err_w, spd_w, err_c, spd_c, spd_abs;

  always_comb begin
    inc     = s1_a_q ^ prev_b_q;
    dec     = s1_b_q ^ prev_a_q;
    cnt_enc = count_q + POS_WIDTH'(inc) - POS_WIDTH'(dec);
    fault_d = s1_func_q ? fault_q
                        : (fault_q | ((s1_a_q != prev_a_q) & (s1_b_q != prev_b_q)));
    count_d = s1_func_q ? count_q : cnt_enc;
    err_w   = EW'(s1_tgt_q) - EW'($signed(count_q));
    spd_w   = EW'($signed(count_q)) - EW'($signed(prev_count_q));
    err_c   = clamp_mag(err_w);
    spd_c   = clamp_mag(spd_w);
    spd_abs = spd_c[EW-1] ? -spd_c : spd_c;
  end

  // stage 2: count after item, clamped error and speed
  logic                 s2_tick_q, s2_fault_q;
  logic [31:0]          s2_pos_q;
  logic signed [CW-1:0] s2_err_q;
  logic [CW-1:0]        s2_spd_q;

  // stage 3: products
  logic                  s3_tick_q, s3_fault_q;
  logic [31:0]           s3_pos_q;
  logic signed [PW-1:0]  s3_p_q, p_d;
  logic [DPW-1:0]        s3_d_q, d_d;

  assign p_d = $signed({1'b0, cfg_q.prop_gain}) * s2_err_q;
  assign d_d = cfg_q.deriv_gain * s2_spd_q;

  // stage 4: saturated torque and direction
  logic                     s4_tick_q, s4_fault_q, s4_dir_q;
  logic [31:0]              s4_pos_q;
  logic signed [TORQ_W-1:0] s4_t_q, t_sat;
  logic signed [TW-1:0]     t_w;
  logic                     t_fits;

  always_comb begin
    t_w    = TW'(s3_p_q) - $signed(TW'(s3_d_q));
    t_fits = (&t_w[TW-1:TORQ_W-1]) | ~(|t_w[TW-1:TORQ_W-1]);
    if (t_fits) begin
      t_sat = t_w[TORQ_W-1:0];
    end else if (t_w[TW-1]) begin
      t_sat = TORQ_MIN;
    end else begin
      t_sat = TORQ_MAX;
    end
  end

  // stage 5: magnitude class and scaled magnitude
  logic                     s5_tick_q, s5_fault_q, s5_dir_q, s5_big_q, s5_small_q;
  logic [31:0]              s5_pos_q;
  logic signed [TORQ_W-1:0] s5_t_q;
  logic [XW-1:0]            s5_x_q, x_d;
  logic [TORQ_W-1:0]        mag;
  logic                     big_d, small_d;

  always_comb begin
    mag     = s4_t_q[TORQ_W-1] ? (~s4_t_q + 32'd1) : s4_t_q;
    big_d   = mag >= 32'(DUTY_BIG_MIN);
    small_d = (mag >= 32'(SMALL_LO)) && (mag <= 32'(SMALL_HI));
    x_d     = (XW'(mag[MLO_W-1:0]) << 8) - XW'(mag[MLO_W-1:0]);
  end

  // stage 6: duty
  logic [QW-1:0]     quot;
  logic [DUTY_W-1:0] duty_d;

  always_comb begin
    quot = (QW'(s5_x_q) * QW'(RECIP)) >> RSH;
    priority if (s5_big_q) begin
      duty_d = DUTY_FULL;
    end else if (s5_small_q) begin
      duty_d = DUTY_LOW;
    end else begin
      duty_d = quot[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q              <= '0;
      cfg_q.prop_gain    <= PROP_GAIN_RST;
      cfg_q.deriv_gain   <= DERIV_GAIN_RST;
      cfg_q.dir_polarity <= 1'b0;
      count_q            <= '0;
      prev_count_q       <= '0;
      prev_a_q           <= 1'b0;
      prev_b_q           <= 1'b0;
      fault_q            <= 1'b0;
      torque_o           <= '0;
      pwm_duty_o         <= '0;
      dir_pin_o          <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_PROP_GAIN:    cfg_q.prop_gain    <= pwdata[GAIN_W-1:0];
          REG_DERIV_GAIN:   cfg_q.deriv_gain   <= pwdata[GAIN_W-1:0];
          REG_DIR_POLARITY: cfg_q.dir_polarity <= pwdata[0];
          default: ;
        endcase
      end
      if (load[1]) begin
        count_q <= count_d;
        fault_q <= fault_d;
        if (s1_func_q) begin
          prev_count_q <= count_q;
        end else begin
          prev_a_q <= s1_a_q;
          prev_b_q <= s1_b_q;
        end
      end
      if (load[5] && s5_tick_q) begin
        torque_o   <= s5_t_q;
        pwm_duty_o <= duty_d;
        dir_pin_o  <= s5_dir_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s1_func_q <= func_i;
      s1_a_q    <= enc_a_i;
      s1_b_q    <= enc_b_i;
      s1_tgt_q  <= target_pos_i;
    end
    if (load[1]) begin
      s2_tick_q  <= s1_func_q;
      s2_fault_q <= fault_d;
      s2_pos_q   <= 32'(count_d);
      s2_err_q   <= err_c[CW-1:0];
      s2_spd_q   <= spd_abs[CW-1:0];
    end
    if (load[2]) begin
      s3_tick_q  <= s2_tick_q;
      s3_fault_q <= s2_fault_q;
      s3_pos_q   <= s2_pos_q;
      s3_p_q     <= p_d;
      s3_d_q     <= d_d;
    end
    if (load[3]) begin
      s4_tick_q  <= s3_tick_q;
      s4_fault_q <= s3_fault_q;
      s4_pos_q   <= s3_pos_q;
      if (s3_tick_q) begin
        s4_t_q   <= t_sat;
        s4_dir_q <= cfg_q.dir_polarity ^ t_sat[TORQ_W-1];
      end
    end
    if (load[4]) begin
      s5_tick_q  <= s4_tick_q;
      s5_fault_q <= s4_fault_q;
      s5_pos_q   <= s4_pos_q;
      if (s4_tick_q) begin
        s5_t_q     <= s4_t_q;
        s5_dir_q   <= s4_dir_q;
        s5_big_q   <= big_d;
        s5_small_q <= small_d;
        s5_x_q     <= x_d;
      end
    end
    if (load[5]) begin
      position_o  <= s5_pos_q;
      enc_fault_o <= s5_fault_q;
    end
  end

endmodule

// ===== hw/rtl/qpdmpc_checker.sv =====
// Port-level checker for the quadrature PD position control unit, with its bind.
// Watches the result channel only; uses qpdmpc_pkg.
module qpdmpc_checker #(
  parameter int unsigned FULL_TORQUE = 4496
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [31:0]                   position_o,
  input logic                                 enc_fault_o,
  input logic signed [qpdmpc_pkg::TORQ_W-1:0] torque_o,
  input logic [qpdmpc_pkg::DUTY_W-1:0]        pwm_duty_o,
  input logic                                 dir_pin_o
);
  import qpdmpc_pkg::*;

  localparam int BIG_T = int'((FULL_TORQUE * int'(DUTY_FULL) + 254) / 255);

  logic fault_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_seen_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && enc_fault_o) begin
      fault_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o) &&
      $stable(enc_fault_o) && $stable(torque_o) && $stable(pwm_duty_o) &&
      $stable(dir_pin_o))
    else $error("result changed while stalled");

  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_seen_q |-> enc_fault_o)
    else $error("encoder fault flag cleared");

  a_full_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pwm_duty_o == DUTY_FULL) |-> (torque_o >= BIG_T) || (torque_o <= -BIG_T))
    else $error("full duty with small torque");

  a_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (torque_o == 0) |-> (pwm_duty_o == '0))
    else $error("nonzero duty with zero torque");

endmodule

bind quadrature_pd_motor_position_control_unit qpdmpc_checker #(
  .FULL_TORQUE(FULL_TORQUE)
) u_qpdmpc_checker (.*);
